/* hw/rtl/ile_pkg.sv */
// Shared types, constants and helpers for the lattice energy core.
`default_nettype none

package ile_pkg;

   localparam int MAX_SIDE   = 64;
   localparam int POS_BITS   = $clog2(MAX_SIDE);
   localparam int VALUE_BITS = 16;
   localparam int TERM_BITS  = VALUE_BITS + 1;
   localparam int SITE_BITS  = TERM_BITS + 3;
   localparam int ACC_BITS   = 40;
   localparam int SUM_BITS   = ACC_BITS + 1;
   localparam int FIRST_BITS = VALUE_BITS + 1;
   localparam int SIDE_BITS  = 7;
   localparam int ADDR_BITS  = 4;
   localparam int DATA_BITS  = 32;

   typedef enum logic [1:0] {
      REG_LATTICE_SIDE    = 2'd0,
      REG_FAVOR_SPIN_UP   = 2'd1,
      REG_FAVOR_ALIGNMENT = 2'd2,
      REG_PERIODIC_WRAP   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [POS_BITS-1:0] side_m1;
      logic                favor_spin_up;
      logic                favor_alignment;
      logic                periodic_wrap;
   } cfg_type;

   // One site as it leaves the input register, with the stored neighbours.
   typedef struct packed {
      logic                         last;
      logic signed [VALUE_BITS-1:0] field;
      logic                         spin;
      logic signed [VALUE_BITS-1:0] up_coupling;
      logic signed [VALUE_BITS-1:0] left_coupling;
      logic                         up_en;
      logic                         left_en;
      logic                         wrap_down_en;
      logic                         wrap_right_en;
      logic                         left_spin;
      logic                         row_start_spin;
      logic signed [VALUE_BITS-1:0] row_start_coupling;
      logic                         above_spin;
      logic                         first_spin;
      logic signed [VALUE_BITS-1:0] first_coupling;
   } site_type;

   function automatic logic signed [TERM_BITS-1:0] cond_neg(
      input logic signed [VALUE_BITS-1:0] value,
      input logic                         neg
   );
      logic signed [TERM_BITS-1:0] wide;
      wide = TERM_BITS'(value);
      return neg ? -wide : wide;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ile_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ile_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read and a write to the same entry return the old data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/ile_csr.sv */
// Configuration registers with clamped side length and restart pulse.
`default_nettype none

module ile_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ile_pkg::ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [ile_pkg::DATA_BITS-1:0]   csr_pwdata,
   output logic      [ile_pkg::DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output ile_pkg::cfg_type                     cfg,
   output logic                                 restart
);

   logic [ile_pkg::SIDE_BITS-1:0] lattice_side_ff;
   logic                          favor_spin_up_ff;
   logic                          favor_alignment_ff;
   logic                          periodic_wrap_ff;
   logic                          write_en;
   ile_pkg::reg_index_type        index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign index      = ile_pkg::reg_index_type'(csr_paddr[3:2]);
   assign restart    = write_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         lattice_side_ff    <= ile_pkg::SIDE_BITS'(3);
         favor_spin_up_ff   <= 1'b1;
         favor_alignment_ff <= 1'b1;
         periodic_wrap_ff   <= 1'b0;
      end else if (write_en) begin
         unique case (index)
            ile_pkg::REG_LATTICE_SIDE: begin
               lattice_side_ff <= csr_pwdata[ile_pkg::SIDE_BITS-1:0];
            end
            ile_pkg::REG_FAVOR_SPIN_UP: begin
               favor_spin_up_ff <= csr_pwdata[0];
            end
            ile_pkg::REG_FAVOR_ALIGNMENT: begin
               favor_alignment_ff <= csr_pwdata[0];
            end
            ile_pkg::REG_PERIODIC_WRAP: begin
               periodic_wrap_ff <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         ile_pkg::REG_LATTICE_SIDE:    csr_prdata = ile_pkg::DATA_BITS'(lattice_side_ff);
         ile_pkg::REG_FAVOR_SPIN_UP:   csr_prdata = ile_pkg::DATA_BITS'(favor_spin_up_ff);
         ile_pkg::REG_FAVOR_ALIGNMENT: csr_prdata = ile_pkg::DATA_BITS'(favor_alignment_ff);
         ile_pkg::REG_PERIODIC_WRAP:   csr_prdata = ile_pkg::DATA_BITS'(periodic_wrap_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // Sides below two act as two, sides beyond the largest lattice as the largest.
   always_comb begin
      cfg.favor_spin_up   = favor_spin_up_ff;
      cfg.favor_alignment = favor_alignment_ff;
      cfg.periodic_wrap   = periodic_wrap_ff;
      priority if (lattice_side_ff < ile_pkg::SIDE_BITS'(2)) begin
         cfg.side_m1 = ile_pkg::POS_BITS'(1);
      end else if (lattice_side_ff > ile_pkg::SIDE_BITS'(ile_pkg::MAX_SIDE)) begin
         cfg.side_m1 = ile_pkg::POS_BITS'(ile_pkg::MAX_SIDE - 1);
      end else begin
         cfg.side_m1 = ile_pkg::POS_BITS'(lattice_side_ff - ile_pkg::SIDE_BITS'(1));
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/ile_front.sv */
// Input register, raster position tracking and neighbour spin stores.
`default_nettype none

module ile_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ile_pkg::cfg_type                     cfg,
   input  wire logic                                 restart,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [ile_pkg::VALUE_BITS-1:0] req_site_field,
   input  wire logic                                 req_spin_up,
   input  wire logic signed [ile_pkg::VALUE_BITS-1:0] req_up_coupling,
   input  wire logic signed [ile_pkg::VALUE_BITS-1:0] req_left_coupling,
   output logic                                      site_valid,
   output ile_pkg::site_type                         site,
   input  wire logic                                 site_take
);

   logic [ile_pkg::POS_BITS-1:0]   row_ff;
   logic [ile_pkg::POS_BITS-1:0]   col_ff;
   logic                           valid_ff;
   logic                           last_spin_ff;
   logic                           row_start_spin_ff;
   logic signed [ile_pkg::VALUE_BITS-1:0] row_start_coupling_ff;
   ile_pkg::site_type              site_ff;
   ile_pkg::site_type              site_in;
   logic                           accept;
   logic                           col_last;
   logic                           row_last;
   logic                           above_spin;
   logic [ile_pkg::FIRST_BITS-1:0] first_rd;

   assign req_ready = !valid_ff || site_take;
   assign accept    = req_valid && req_ready;
   assign col_last  = (col_ff == cfg.side_m1);
   assign row_last  = (row_ff == cfg.side_m1);

   always_comb begin
      site_in                    = site_ff;
      site_in.last               = col_last && row_last;
      site_in.field              = req_site_field;
      site_in.spin               = req_spin_up;
      site_in.up_coupling        = req_up_coupling;
      site_in.left_coupling      = req_left_coupling;
      site_in.up_en              = (row_ff != '0);
      site_in.left_en            = (col_ff != '0);
      site_in.wrap_down_en       = cfg.periodic_wrap && row_last;
      site_in.wrap_right_en      = cfg.periodic_wrap && col_last;
      site_in.left_spin          = last_spin_ff;
      site_in.row_start_spin     = row_start_spin_ff;
      site_in.row_start_coupling = row_start_coupling_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff              <= 1'b0;
         row_ff                <= '0;
         col_ff                <= '0;
         row_start_spin_ff     <= 1'b0;
         row_start_coupling_ff <= '0;
      end else begin
         if (accept) begin
            valid_ff <= 1'b1;
         end else if (site_take) begin
            valid_ff <= 1'b0;
         end
         if (restart) begin
            row_ff <= '0;
            col_ff <= '0;
         end else if (accept) begin
            if (col_last) begin
               col_ff <= '0;
               row_ff <= row_last ? '0 : row_ff + ile_pkg::POS_BITS'(1);
            end else begin
               col_ff <= col_ff + ile_pkg::POS_BITS'(1);
            end
         end
         if (accept && (col_ff == '0)) begin
            row_start_spin_ff     <= req_spin_up;
            row_start_coupling_ff <= req_left_coupling;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         site_ff      <= site_in;
         last_spin_ff <= req_spin_up;
      end
   end

   // Spins of the row above; the entry for this column is read before it is overwritten.
   ile_ram #(
      .WIDTH (1),
      .DEPTH (ile_pkg::MAX_SIDE)
   ) u_above_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_spin_up),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above_spin)
   );

   // Row 0 spins and their wrap couplings, read back on the last row.
   ile_ram #(
      .WIDTH (ile_pkg::FIRST_BITS),
      .DEPTH (ile_pkg::MAX_SIDE)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (accept && (row_ff == '0)),
      .wr_addr (col_ff),
      .wr_data ({req_spin_up, req_up_coupling}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (first_rd)
   );

   always_comb begin
      site                = site_ff;
      site.above_spin     = above_spin;
      site.first_spin     = first_rd[ile_pkg::FIRST_BITS-1];
      site.first_coupling = first_rd[ile_pkg::VALUE_BITS-1:0];
   end

   assign site_valid = valid_ff;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= cfg.side_m1) && (row_ff <= cfg.side_m1))
      else $error("raster position beyond lattice side");

   a_ready_only_blocked_by_stage: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> valid_ff && !site_take)
      else $error("input held off without a stalled site");

endmodule

`default_nettype wire

/* hw/rtl/ile_accum.sv */
// Per-site term sum, saturating energy accumulator and result register.
`default_nettype none

module ile_accum (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire ile_pkg::cfg_type                      cfg,
   input  wire logic                                  restart,
   input  wire logic                                  site_valid,
   input  wire ile_pkg::site_type                     site,
   output logic                                       site_take,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [ile_pkg::ACC_BITS-1:0]        rsp_total_energy,
   output logic                                       rsp_saturated
);

   logic signed [ile_pkg::ACC_BITS-1:0]  acc_ff;
   logic                                 sat_ff;
   logic                                 rsp_valid_ff;
   logic signed [ile_pkg::ACC_BITS-1:0]  rsp_energy_ff;
   logic                                 rsp_sat_ff;
   logic signed [ile_pkg::TERM_BITS-1:0] field_term;
   logic signed [ile_pkg::TERM_BITS-1:0] up_term;
   logic signed [ile_pkg::TERM_BITS-1:0] down_term;
   logic signed [ile_pkg::TERM_BITS-1:0] left_term;
   logic signed [ile_pkg::TERM_BITS-1:0] right_term;
   logic signed [ile_pkg::SITE_BITS-1:0] site_sum;
   logic signed [ile_pkg::SUM_BITS-1:0]  sum;
   logic signed [ile_pkg::ACC_BITS-1:0]  acc_in;
   logic                                 clip;
   logic                                 slot_free;

   // A bond is negated when alignment is favoured and the pair agrees, or vice versa.
   always_comb begin
      field_term = ile_pkg::cond_neg(site.field, cfg.favor_spin_up == site.spin);
      up_term    = site.up_en
                 ? ile_pkg::cond_neg(site.up_coupling,
                      cfg.favor_alignment == (site.spin == site.above_spin))
                 : '0;
      down_term  = site.wrap_down_en
                 ? ile_pkg::cond_neg(site.first_coupling,
                      cfg.favor_alignment == (site.spin == site.first_spin))
                 : '0;
      left_term  = site.left_en
                 ? ile_pkg::cond_neg(site.left_coupling,
                      cfg.favor_alignment == (site.spin == site.left_spin))
                 : '0;
      right_term = site.wrap_right_en
                 ? ile_pkg::cond_neg(site.row_start_coupling,
                      cfg.favor_alignment == (site.spin == site.row_start_spin))
                 : '0;
      site_sum   = ile_pkg::SITE_BITS'(field_term) + ile_pkg::SITE_BITS'(up_term)
                 + ile_pkg::SITE_BITS'(down_term) + ile_pkg::SITE_BITS'(left_term)
                 + ile_pkg::SITE_BITS'(right_term);
      sum        = ile_pkg::SUM_BITS'(acc_ff) + ile_pkg::SUM_BITS'(site_sum);
      clip       = (sum[ile_pkg::SUM_BITS-1] != sum[ile_pkg::SUM_BITS-2]);
      if (!clip) begin
         acc_in = sum[ile_pkg::ACC_BITS-1:0];
      end else if (sum[ile_pkg::SUM_BITS-1]) begin
         acc_in = {1'b1, {(ile_pkg::ACC_BITS-1){1'b0}}};
      end else begin
         acc_in = {1'b0, {(ile_pkg::ACC_BITS-1){1'b1}}};
      end
   end

   // Only the final site of a lattice needs the result register to be free.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign site_take = site_valid && (!site.last || slot_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (restart || (site_take && site.last)) begin
            acc_ff <= '0;
            sat_ff <= 1'b0;
         end else if (site_take) begin
            acc_ff <= acc_in;
            sat_ff <= sat_ff || clip;
         end
         if (site_take && site.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (site_take && site.last) begin
         rsp_energy_ff <= acc_in;
         rsp_sat_ff    <= sat_ff || clip;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_energy = rsp_energy_ff;
   assign rsp_saturated    = rsp_sat_ff;

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      site_take && site.last |=> (acc_ff == '0) && !sat_ff && rsp_valid_ff)
      else $error("accumulator not cleared after final site");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(site_take && site.last))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

/* hw/rtl/ising_lattice_energy_core.sv */
// Top level of the streaming Ising lattice energy core.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   site_field, spin_up, up/left_coupling
//   rsp_      out        rsp_valid/rsp_ready   total_energy, saturated
//   csr_      in         APB, pready tied high lattice_side, favour flags, wrap
//
// One site is taken every cycle unless the final site waits on a pending result;
// a site passes the input register, then its terms are summed into the accumulator
// or, for the final site, into the result register. The neighbour stores are RAMs
// with one write port and one registered read port, both used at the site's column
// on the transfer. Reset clears positions, the sum and the flag. Only the final site
// of a lattice waits on a pending result, and the input is held while it waits.
`default_nettype none

module ising_lattice_energy_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [ile_pkg::VALUE_BITS-1:0] req_site_field,
   input  wire logic                                  req_spin_up,
   input  wire logic signed [ile_pkg::VALUE_BITS-1:0] req_up_coupling,
   input  wire logic signed [ile_pkg::VALUE_BITS-1:0] req_left_coupling,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [ile_pkg::ACC_BITS-1:0]        rsp_total_energy,
   output logic                                       rsp_saturated,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [ile_pkg::ADDR_BITS-1:0]         csr_paddr,
   input  wire logic [ile_pkg::DATA_BITS-1:0]         csr_pwdata,
   output logic      [ile_pkg::DATA_BITS-1:0]         csr_prdata,
   output logic                                       csr_pready
);

   ile_pkg::cfg_type  cfg;
   ile_pkg::site_type site;
   logic              restart;
   logic              site_valid;
   logic              site_take;

   ile_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .restart     (restart)
   );

   ile_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .restart           (restart),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_site_field    (req_site_field),
      .req_spin_up       (req_spin_up),
      .req_up_coupling   (req_up_coupling),
      .req_left_coupling (req_left_coupling),
      .site_valid        (site_valid),
      .site              (site),
      .site_take         (site_take)
   );

   ile_accum u_accum (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .restart          (restart),
      .site_valid       (site_valid),
      .site             (site),
      .site_take        (site_take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_total_energy (rsp_total_energy),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

`default_nettype wire

/* dv/ising_lattice_energy_core_tb.sv */
// Self-checking testbench for the streaming Ising lattice energy core.
`timescale 1ns / 1ps

module ising_lattice_energy_core_tb;

   localparam int     RANDOM_SITES  = 470;
   localparam int     SETTLE_CYCLES = 6;
   localparam int     CYCLE_LIMIT   = 400000;
   localparam longint ENERGY_MAX    = 64'sd549755813887;
   localparam longint ENERGY_MIN    = -64'sd549755813888;

   typedef enum int {
      LIGHT_SEND_HEAVY_RECV,
      HEAVY_SEND_LIGHT_RECV,
      FULL_RATE
   } traffic_type;

   typedef struct {
      logic signed [ile_pkg::VALUE_BITS-1:0] field;
      logic                                  spin;
      logic signed [ile_pkg::VALUE_BITS-1:0] up_j;
      logic signed [ile_pkg::VALUE_BITS-1:0] left_j;
   } site_item_type;

   typedef struct {
      logic signed [ile_pkg::ACC_BITS-1:0] energy;
      logic                                saturated;
   } energy_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_ready;
   site_item_type                       held_site = '{default: '0};
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [ile_pkg::ACC_BITS-1:0] rsp_total_energy;
   logic                                rsp_saturated;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [ile_pkg::ADDR_BITS-1:0]       csr_paddr = '0;
   logic [ile_pkg::DATA_BITS-1:0]       csr_pwdata = '0;
   logic [ile_pkg::DATA_BITS-1:0]       csr_prdata;
   logic                                csr_pready;

   site_item_type     site_queue[$];
   energy_result_type energy_expected[$];
   traffic_type       traffic = LIGHT_SEND_HEAVY_RECV;
   int                error_count = 0;
   int                cycle_count = 0;

   // Predictor state: configuration, neighbour stores and the running sum.
   logic [ile_pkg::SIDE_BITS-1:0]         cfg_side = 7'd3;
   logic                                  cfg_field_neg = 1'b1;
   logic                                  cfg_bond_neg = 1'b1;
   logic                                  cfg_wrap = 1'b0;
   logic                                  above_spins[ile_pkg::MAX_SIDE];
   logic                                  top_spins[ile_pkg::MAX_SIDE];
   logic signed [ile_pkg::VALUE_BITS-1:0] top_wrap_j[ile_pkg::MAX_SIDE];
   logic                                  row_head_spin = 1'b0;
   logic signed [ile_pkg::VALUE_BITS-1:0] row_head_j = '0;
   longint                                energy_acc = 0;
   logic                                  clip_seen = 1'b0;
   int                                    cur_row = 0;
   int                                    cur_col = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ising_lattice_energy_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_site_field    (held_site.field),
      .req_spin_up       (held_site.spin),
      .req_up_coupling   (held_site.up_j),
      .req_left_coupling (held_site.left_j),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_total_energy  (rsp_total_energy),
      .rsp_saturated     (rsp_saturated),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   function automatic int active_side();
      if (cfg_side < 2) return 2;
      if (cfg_side > ile_pkg::MAX_SIDE) return ile_pkg::MAX_SIDE;
      return int'(cfg_side);
   endfunction

   function automatic longint flip_sign(input longint value, input logic neg);
      return neg ? -value : value;
   endfunction

   function automatic longint bond_energy(input logic signed [ile_pkg::VALUE_BITS-1:0] j,
                                          input logic sa, input logic sb);
      return flip_sign(longint'(j), cfg_bond_neg != (sa != sb));
   endfunction

   function automatic void restart_lattice();
      energy_acc = 0;
      clip_seen  = 1'b0;
      cur_row    = 0;
      cur_col    = 0;
   endfunction

   // Adds one site's field and bond terms; queues the energy after the final site.
   task automatic accumulate_site(input site_item_type s);
      int                n;
      int                r;
      int                c;
      longint            terms;
      longint            acc;
      energy_result_type res;
      n = active_side();
      r = (cur_row >= n) ? n - 1 : cur_row;
      c = (cur_col >= n) ? n - 1 : cur_col;
      terms = flip_sign(longint'(s.field), cfg_field_neg != !s.spin);
      if (r > 0) terms += bond_energy(s.up_j, s.spin, above_spins[c]);
      if (cfg_wrap && r == n - 1) terms += bond_energy(top_wrap_j[c], s.spin, top_spins[c]);
      if (c > 0) terms += bond_energy(s.left_j, s.spin, above_spins[c-1]);
      if (c == 0) begin
         row_head_spin = s.spin;
         row_head_j    = s.left_j;
      end
      if (cfg_wrap && c == n - 1) terms += bond_energy(row_head_j, s.spin, row_head_spin);
      if (r == 0) begin
         top_spins[c]  = s.spin;
         top_wrap_j[c] = s.up_j;
      end
      // The row store is written after the left neighbour has been read from it.
      above_spins[c] = s.spin;
      acc = energy_acc + terms;
      if (acc > ENERGY_MAX) begin
         acc = ENERGY_MAX;
         clip_seen = 1'b1;
      end
      if (acc < ENERGY_MIN) begin
         acc = ENERGY_MIN;
         clip_seen = 1'b1;
      end
      energy_acc = acc;
      if (c + 1 < n) begin
         cur_col = c + 1;
         cur_row = r;
      end else if (r + 1 < n) begin
         cur_col = 0;
         cur_row = r + 1;
      end else begin
         res.energy    = acc[ile_pkg::ACC_BITS-1:0];
         res.saturated = clip_seen;
         energy_expected.push_back(res);
         restart_lattice();
      end
   endtask

   function automatic logic sender_gap();
      case (traffic)
         LIGHT_SEND_HEAVY_RECV: return $urandom_range(0, 99) < 7;
         HEAVY_SEND_LIGHT_RECV: return $urandom_range(0, 99) < 70;
         default:               return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stall();
      case (traffic)
         LIGHT_SEND_HEAVY_RECV: return $urandom_range(0, 99) < 70;
         HEAVY_SEND_LIGHT_RECV: return $urandom_range(0, 99) < 7;
         default:               return 1'b0;
      endcase
   endfunction

   // Site driver: holds each site until its transfer, then takes the next one.
   always @(posedge clock) begin
      logic launch;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) accumulate_site(held_site);
         if (!req_valid || req_ready) begin
            launch = (site_queue.size() != 0) && !sender_gap();
            if (launch) held_site <= site_queue.pop_front();
            req_valid <= launch;
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      energy_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (energy_expected.size() == 0) begin
               $display("%0t: unexpected result, energy %0d saturated %0b",
                        $time, rsp_total_energy, rsp_saturated);
               error_count++;
            end else begin
               want = energy_expected.pop_front();
               if (rsp_total_energy !== want.energy) begin
                  $display("%0t: total_energy expected %0d actual %0d",
                           $time, want.energy, rsp_total_energy);
                  error_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $display("%0t: saturated expected %0b actual %0b",
                           $time, want.saturated, rsp_saturated);
                  error_count++;
               end
            end
         end
         rsp_ready <= !receiver_stall();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic signed [ile_pkg::VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return ile_pkg::VALUE_BITS'($urandom);
      endcase
   endfunction

   task automatic push_site(input logic signed [ile_pkg::VALUE_BITS-1:0] field,
                            input logic spin,
                            input logic signed [ile_pkg::VALUE_BITS-1:0] up_j,
                            input logic signed [ile_pkg::VALUE_BITS-1:0] left_j);
      site_item_type s;
      s.field  = field;
      s.spin   = spin;
      s.up_j   = up_j;
      s.left_j = left_j;
      site_queue.push_back(s);
   endtask

   task automatic push_sites(input int count);
      repeat (count) push_site(pick_value(), 1'($urandom), pick_value(), pick_value());
   endtask

   // Waits until the block has drained and any final site is through the pipeline.
   task automatic wait_for_quiet();
      do @(negedge clock);
      while (site_queue.size() != 0 || req_valid || energy_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input ile_pkg::reg_index_type index,
                                 input logic [ile_pkg::DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         ile_pkg::REG_LATTICE_SIDE:    cfg_side      = value[ile_pkg::SIDE_BITS-1:0];
         ile_pkg::REG_FAVOR_SPIN_UP:   cfg_field_neg = value[0];
         ile_pkg::REG_FAVOR_ALIGNMENT: cfg_bond_neg  = value[0];
         ile_pkg::REG_PERIODIC_WRAP:   cfg_wrap      = value[0];
         default: ;
      endcase
      restart_lattice();
   endtask

   task automatic reconfigure_randomly();
      logic [3:0] chosen;
      int         side_value;
      chosen = 4'($urandom);
      if (chosen == 4'b0000) chosen = 4'b0001;
      case ($urandom_range(0, 9))
         0:       side_value = 0;
         1:       side_value = 1;
         2:       side_value = 2;
         default: side_value = $urandom_range(2, 6);
      endcase
      if (chosen[0]) write_register(ile_pkg::REG_LATTICE_SIDE, side_value);
      if (chosen[1]) write_register(ile_pkg::REG_FAVOR_SPIN_UP, $urandom_range(0, 1));
      if (chosen[2]) write_register(ile_pkg::REG_FAVOR_ALIGNMENT, $urandom_range(0, 1));
      if (chosen[3]) write_register(ile_pkg::REG_PERIODIC_WRAP, $urandom_range(0, 1));
   endtask

   initial begin
      int placed;
      int n;
      foreach (above_spins[i]) begin
         above_spins[i] = 1'b0;
         top_spins[i]   = 1'b0;
         top_wrap_j[i]  = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: three by three, both favour flags set, open edges.
      push_site(16'h8000, 1'b1, 16'h7FFF, 16'h8000);
      push_site(16'h7FFF, 1'b0, 16'h8000, 16'h7FFF);
      push_site(16'h0000, 1'b1, 16'hFFFF, 16'h0000);
      push_site(16'h0001, 1'b0, 16'h7FFF, 16'h7FFF);
      push_site(16'hFFFF, 1'b1, 16'h8000, 16'h8000);
      push_site(16'h7FFF, 1'b1, 16'h0000, 16'h0001);
      push_site(16'h8000, 1'b0, 16'h7FFF, 16'hFFFF);
      push_site(16'h0000, 1'b0, 16'h8000, 16'h7FFF);
      push_site(16'h3039, 1'b1, 16'h8000, 16'h8000);
      wait_for_quiet();

      // A side below the minimum acts as two; wrap bonds close on both edges.
      write_register(ile_pkg::REG_LATTICE_SIDE, 1);
      write_register(ile_pkg::REG_FAVOR_SPIN_UP, 0);
      write_register(ile_pkg::REG_FAVOR_ALIGNMENT, 0);
      write_register(ile_pkg::REG_PERIODIC_WRAP, 1);
      push_site(16'h8000, 1'b1, 16'h8000, 16'h8000);
      push_site(16'h7FFF, 1'b1, 16'h7FFF, 16'h7FFF);
      push_site(16'h8000, 1'b0, 16'h7FFF, 16'h8000);
      push_site(16'h7FFF, 1'b1, 16'h8000, 16'h7FFF);
      wait_for_quiet();
      write_register(ile_pkg::REG_LATTICE_SIDE, 0);
      write_register(ile_pkg::REG_FAVOR_ALIGNMENT, 1);
      push_site(16'h7FFF, 1'b0, 16'h7FFF, 16'h8000);
      push_site(16'h8000, 1'b0, 16'h8000, 16'h7FFF);
      push_site(16'h0000, 1'b1, 16'hFFFF, 16'h0001);
      push_site(16'hFFFF, 1'b0, 16'h0001, 16'hFFFF);

      // A register write part way through a lattice throws the partial sum away.
      push_sites(3);
      wait_for_quiet();
      write_register(ile_pkg::REG_FAVOR_SPIN_UP, 1);
      push_sites(4);

      placed = 0;
      while (placed < RANDOM_SITES) begin
         if (placed >= RANDOM_SITES / 2) traffic = HEAVY_SEND_LIGHT_RECV;
         wait_for_quiet();
         reconfigure_randomly();
         n = active_side();
         repeat ($urandom_range(1, 3)) begin
            push_sites(n * n);
            placed += n * n;
         end
         // Now and then leave a lattice unfinished; the next write restarts it.
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, n * n - 1);
            push_sites(n);
            placed += n;
         end
      end

      // A side at the top of the register range acts as the largest; the rows
      // run past the width of a small lattice before the next write drops them.
      traffic = FULL_RATE;
      wait_for_quiet();
      write_register(ile_pkg::REG_LATTICE_SIDE, 127);
      write_register(ile_pkg::REG_PERIODIC_WRAP, 1);
      write_register(ile_pkg::REG_FAVOR_SPIN_UP, $urandom_range(0, 1));
      push_sites(ile_pkg::MAX_SIDE + 6);
      wait_for_quiet();
      write_register(ile_pkg::REG_LATTICE_SIDE, 2);
      push_sites(12);

      wait_for_quiet();
      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
